// ----- rtl/bbsm_pkg.sv -----
// Package for the Bark band spectral mask unit: payload structs, constants,
// band edge and threshold tables. No dependencies.
package bbsm_pkg;

  localparam int MaxFftLength = 2048;
  localparam int BandCount    = 24;
  localparam int SampleWidth  = 24;
  localparam int EnergyWidth  = 48;

  localparam logic [17:0] SampleRateReset = 18'd48000;
  localparam logic [11:0] FftLengthReset  = 12'd1024;
  localparam logic [15:0] ThrMultReset    = 16'd256;

  localparam logic [1:0] RegSampleRate = 2'd0;
  localparam logic [1:0] RegFftLength  = 2'd1;
  localparam logic [1:0] RegThrMult    = 2'd2;

  typedef struct packed {
    logic                          cmd;
    logic signed [SampleWidth-1:0] bin_real;
    logic signed [SampleWidth-1:0] bin_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] out_real;
    logic signed [SampleWidth-1:0] out_imag;
    logic                          out_masked;
    logic                          out_last;
    logic [10:0]                   masked_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BAND, ST_SQRT, ST_ACC, ST_READ, ST_CMP, ST_OUT
  } state_e;

  function automatic logic [13:0] edge_hz(input logic [4:0] k);
    logic [13:0] e;
    case (k)
      5'd0: e = 14'd101;    5'd1: e = 14'd204;    5'd2: e = 14'd309;
      5'd3: e = 14'd417;    5'd4: e = 14'd531;    5'd5: e = 14'd651;
      5'd6: e = 14'd781;    5'd7: e = 14'd922;    5'd8: e = 14'd1079;
      5'd9: e = 14'd1255;   5'd10: e = 14'd1456;  5'd11: e = 14'd1691;
      5'd12: e = 14'd1968;  5'd13: e = 14'd2303;  5'd14: e = 14'd2711;
      5'd15: e = 14'd3211;  5'd16: e = 14'd3822;  5'd17: e = 14'd4554;
      5'd18: e = 14'd5412;  5'd19: e = 14'd6414;  5'd20: e = 14'd7617;
      5'd21: e = 14'd9167;  5'd22: e = 14'd11415; 5'd23: e = 14'd15429;
      default: e = 14'd0;
    endcase
    return e;
  endfunction

  function automatic logic [11:0] thr2(input logic [4:0] k);
    logic [11:0] t;
    case (k)
      5'd0: t = 12'd1000; 5'd1: t = 12'd600;  5'd2: t = 12'd300;
      5'd3: t = 12'd200;  5'd4: t = 12'd100;  5'd5: t = 12'd40;
      5'd6: t = 12'd20;   5'd7: t = 12'd10;   5'd8: t = 12'd4;
      5'd9: t = 12'd2;    5'd10: t = 12'd1;   5'd11: t = 12'd1;
      5'd12: t = 12'd1;   5'd13: t = 12'd2;   5'd14: t = 12'd4;
      5'd15: t = 12'd10;  5'd16: t = 12'd20;  5'd17: t = 12'd40;
      5'd18: t = 12'd100; 5'd19: t = 12'd200; 5'd20: t = 12'd400;
      5'd21: t = 12'd1000; 5'd22: t = 12'd2000; 5'd23: t = 12'd4000;
      default: t = 12'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/bbsm_isqrt.sv -----
// Bit-serial magnitude unit: squares two samples by shift-and-add, one
// multiplier bit per cycle, then takes the integer square root bit by bit.
// Depends on bbsm_pkg.
module bbsm_isqrt #(
  parameter int SampleWidth = bbsm_pkg::SampleWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SampleWidth-1:0] re_i,
  input  logic [SampleWidth-1:0] im_i,
  output logic                   done_o,
  output logic [SampleWidth:0]   mag_o
);
  localparam int AW = SampleWidth;          // magnitude bits of |x|
  localparam int SW = 2 * AW + 2;           // sum of squares, even
  localparam int RW = SW / 2;
  localparam int CW = $clog2(AW + RW + 1);

  logic [AW:0]   ma_q, ma_d, mb_q, mb_d;    // shifting multipliers
  logic [SW-1:0] v_q, v_d;                  // accumulated sum, then shifted into the root
  logic [SW-1:0] pa_q, pa_d, pb_q, pb_d;    // shifted multiplicands
  logic [RW:0]   r_q, r_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, sq_q, sq_d, done_q, done_d;
  logic [AW:0]   abs_re, abs_im;
  logic [SW+1:0] trial;
  logic [SW+1:0] rem_sh;

  assign abs_re = re_i[AW-1] ? ({1'b0, ~re_i} + 1'b1) : {1'b0, re_i};
  assign abs_im = im_i[AW-1] ? ({1'b0, ~im_i} + 1'b1) : {1'b0, im_i};
  // Next remainder window brings in the top two bits of v.
  assign rem_sh = {rem_q, v_q[SW-1 -: 2]};
  assign trial  = {{(SW+1-RW-2){1'b0}}, r_q, 2'b01};

  always_comb begin
    ma_d = ma_q; mb_d = mb_q; v_d = v_q;
    pa_d = pa_q; pb_d = pb_q; r_d = r_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; sq_d = sq_q; done_d = 1'b0;
    if (start_i && !busy_q) begin
      ma_d = abs_re; mb_d = abs_im;
      pa_d = {{(SW-AW-1){1'b0}}, abs_re};
      pb_d = {{(SW-AW-1){1'b0}}, abs_im};
      v_d = '0; r_d = '0; rem_d = '0;
      cnt_d = CW'(AW + 1); busy_d = 1'b1; sq_d = 1'b1;
    end else if (busy_q && sq_q) begin
      // Add one partial product of each square.
      v_d = v_q + (ma_q[0] ? pa_q : '0) + (mb_q[0] ? pb_q : '0);
      ma_d = ma_q >> 1; mb_d = mb_q >> 1;
      pa_d = pa_q << 1; pb_d = pb_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        sq_d = 1'b0; cnt_d = CW'(RW);
      end
    end else if (busy_q) begin
      // Restoring root: one result bit per cycle.
      v_d = v_q << 2;
      if (rem_sh >= trial) begin
        rem_d = SW'(rem_sh - trial);
        r_d   = {r_q[RW-1:0], 1'b1};
      end else begin
        rem_d = SW'(rem_sh);
        r_d   = {r_q[RW-1:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; sq_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; sq_q <= sq_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= ma_d; mb_q <= mb_d; v_q <= v_d;
    pa_q <= pa_d; pb_q <= pb_d; r_q <= r_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign mag_o  = r_q[AW:0];
endmodule

// ----- rtl/bark_band_spectral_mask_unit.sv -----
// Top level of the Bark band spectral mask unit: control sequencer, bin store,
// band energy store. Depends on bbsm_pkg and bbsm_isqrt.
//
// Load transactions (cmd=0) store a bin and add its magnitude to its Bark band;
// each runs the band search (one edge compared per cycle) and then the
// bit-serial square and root. Read-out transactions (cmd=1) run the band
// search, a bin store read and one threshold compare. One transaction is in
// flight at a time. A held read-out result does not block the input: loads
// go on, and the next read-out waits before its compare until the result
// register is free. The bin store has no reset; band energies are cleared by
// valid bits at the first load of each frame.
module bark_band_spectral_mask_unit #(
  parameter int MaxFftLength = bbsm_pkg::MaxFftLength
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bbsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bbsm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [17:0]         cfg_data_i
);
  localparam int SampleWidth = bbsm_pkg::SampleWidth;
  localparam int Depth = MaxFftLength / 2 + 1;
  localparam int IW    = $clog2(Depth);
  localparam int LW    = $clog2(MaxFftLength + 1);
  localparam int BC    = bbsm_pkg::BandCount;
  localparam int EW    = bbsm_pkg::EnergyWidth;
  localparam int FW    = IW + 18;               // bin * sample rate
  localparam int GW    = 14 + LW;               // edge * length

  // Configuration registers.
  logic [17:0] srate_q;
  logic [11:0] flen_q;
  logic [15:0] tmul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srate_q <= bbsm_pkg::SampleRateReset;
      flen_q  <= bbsm_pkg::FftLengthReset;
      tmul_q  <= bbsm_pkg::ThrMultReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbsm_pkg::RegSampleRate: srate_q <= cfg_data_i;
        bbsm_pkg::RegFftLength:  flen_q  <= cfg_data_i[11:0];
        bbsm_pkg::RegThrMult:    tmul_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Effective length and bins per frame.
  logic [LW-1:0] len;
  logic [IW:0]   nbins;
  always_comb begin
    if (flen_q < 12'd16) len = LW'(16);
    else if ({{(LW > 12 ? LW-12 : 0){1'b0}}, flen_q} > LW'(MaxFftLength))
      len = LW'(MaxFftLength);
    else len = LW'(flen_q);
    nbins = (IW+1)'(len >> 1) + 1'b1;
  end

  // Control state.
  bbsm_pkg::state_e state_q, state_d;
  logic [IW:0]   load_idx_q, load_idx_d, read_idx_q, read_idx_d;
  logic [10:0]   mcount_q, mcount_d;
  logic [4:0]    k_q, k_d, band_q, band_d;
  logic [BC-1:0] evalid_q, evalid_d;
  logic          rd_q, rd_d;
  logic [SampleWidth-1:0] re_q, im_q;
  logic [FW-1:0] freq_q;
  logic          ovalid_q, ovalid_d;
  bbsm_pkg::out_item_t odata_q, odata_d;

  // Memories: bin store and band energies.
  logic [2*SampleWidth-1:0] store_mem [Depth];
  logic [2*SampleWidth-1:0] store_rd_q;
  logic [EW-1:0] energy_mem [BC];
  logic [EW-1:0] energy_rd_q;

  logic          sq_start, sq_done;
  logic [SampleWidth:0] mag;
  logic          accept;
  logic [GW-1:0] gate;
  logic          store_we, energy_we;
  logic [EW-1:0] energy_wd;
  logic [EW:0]   esum;
  logic [IW-1:0] addr;
  logic [EW:0]   lhs;
  logic [27:0]   rhs;

  assign in_stall_o = (state_q != bbsm_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign gate       = GW'(bbsm_pkg::edge_hz(k_q)) * GW'(len);
  assign addr       = (state_q == bbsm_pkg::ST_IDLE) ? load_idx_q[IW-1:0] : read_idx_q[IW-1:0];
  assign esum       = {1'b0, evalid_q[band_q] ? energy_rd_q : EW'(0)} + (EW+1)'(mag);
  assign lhs        = {evalid_q[band_q] ? energy_rd_q : EW'(0), 1'b0};
  assign rhs        = 28'(bbsm_pkg::thr2(band_q)) * 28'(tmul_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbsm_pkg::ST_IDLE: if (accept) begin
        if (in_data_i.cmd) state_d = bbsm_pkg::ST_BAND;
        else if (load_idx_q < nbins) state_d = bbsm_pkg::ST_BAND;
      end
      bbsm_pkg::ST_BAND: if (k_q == 5'(BC - 1))
        state_d = rd_q ? bbsm_pkg::ST_READ : bbsm_pkg::ST_SQRT;
      bbsm_pkg::ST_SQRT: if (sq_done) state_d = bbsm_pkg::ST_ACC;
      bbsm_pkg::ST_ACC:  state_d = bbsm_pkg::ST_IDLE;
      // Hold the read until the result register is free.
      bbsm_pkg::ST_READ: if (!ovalid_q) state_d = bbsm_pkg::ST_CMP;
      bbsm_pkg::ST_CMP:  state_d = bbsm_pkg::ST_OUT;
      bbsm_pkg::ST_OUT:  state_d = bbsm_pkg::ST_IDLE;
      default:           state_d = bbsm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs. rd_q marks a read-out while busy.
  always_comb begin
    load_idx_d = load_idx_q; read_idx_d = read_idx_q; mcount_d = mcount_q;
    k_d = k_q; band_d = band_q; evalid_d = evalid_q; ovalid_d = ovalid_q;
    rd_d = rd_q;
    odata_d = odata_q; sq_start = 1'b0; store_we = 1'b0; energy_we = 1'b0;
    energy_wd = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      bbsm_pkg::ST_IDLE: if (accept) begin
        k_d = '0; band_d = '0;
        rd_d = in_data_i.cmd;
        if (!in_data_i.cmd && load_idx_q < nbins) begin
          store_we = 1'b1;
          if (load_idx_q == '0) begin
            evalid_d = '0; mcount_d = '0; read_idx_d = '0;
          end
        end
      end
      bbsm_pkg::ST_BAND: begin
        // Count one edge per cycle.
        if ({{(GW > FW ? GW-FW : 0){1'b0}}, freq_q} >= {{(FW > GW ? FW-GW : 0){1'b0}}, gate})
          band_d = band_q + 1'b1;
        k_d = k_q + 1'b1;
        sq_start = (k_q == 5'(BC - 1)) && !rd_q;
      end
      bbsm_pkg::ST_ACC: begin
        if (band_q != 5'(BC)) begin
          energy_we = 1'b1;
          energy_wd = esum[EW] ? {EW{1'b1}} : esum[EW-1:0];
          evalid_d[band_q] = 1'b1;
        end
        load_idx_d = load_idx_q + 1'b1;
      end
      bbsm_pkg::ST_CMP: begin
        odata_d.out_real = store_rd_q[2*SampleWidth-1 -: SampleWidth];
        odata_d.out_imag = store_rd_q[SampleWidth-1:0];
        odata_d.out_masked = 1'b0;
        if (band_q != 5'(BC) && lhs < (EW+1)'(rhs)) begin
          odata_d.out_masked = 1'b1;
          odata_d.out_real = '0;
          odata_d.out_imag = '0;
          mcount_d = mcount_q + 1'b1;
        end
      end
      bbsm_pkg::ST_OUT: begin
        ovalid_d = 1'b1;
        odata_d.out_last = (read_idx_q + 1'b1 >= nbins);
        odata_d.masked_total = odata_d.out_last ? mcount_q : '0;
        if (odata_d.out_last) begin
          read_idx_d = '0; load_idx_d = '0; mcount_d = '0;
        end else begin
          read_idx_d = read_idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbsm_pkg::ST_IDLE; load_idx_q <= '0; read_idx_q <= '0;
      mcount_q <= '0; evalid_q <= '0; ovalid_q <= 1'b0; k_q <= '0; band_q <= '0;
      rd_q <= 1'b0;
    end else begin
      state_q <= state_d; load_idx_q <= load_idx_d; read_idx_q <= read_idx_d;
      mcount_q <= mcount_d; evalid_q <= evalid_d; ovalid_q <= ovalid_d;
      k_q <= k_d; band_q <= band_d; rd_q <= rd_d;
    end
  end

  // Payload registers: capture operands, frequency of the addressed bin.
  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (accept) begin
      re_q <= SampleWidth'(in_data_i.bin_real);
      im_q <= SampleWidth'(in_data_i.bin_imag);
      freq_q <= FW'(in_data_i.cmd ? read_idx_q : load_idx_q) * FW'(srate_q);
    end
    if (store_we) store_mem[addr] <= {SampleWidth'(in_data_i.bin_real),
                                      SampleWidth'(in_data_i.bin_imag)};
    store_rd_q <= store_mem[addr];
    if (energy_we) energy_mem[band_q] <= energy_wd;
    energy_rd_q <= energy_mem[band_q];
  end

  bbsm_isqrt #(.SampleWidth(SampleWidth)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .re_i    (re_q),
    .im_i    (im_q),
    .done_o  (sq_done),
    .mag_o   (mag)
  );

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for bark_band_spectral_mask_unit: drives load and read-out
// transactions, predicts every read-out result and checks it. Depends on bbsm_pkg and the unit.
`timescale 1ns / 1ps

module tb_top;

  localparam bit CmdLoad = 1'b0;
  localparam bit CmdRead = 1'b1;
  localparam int StoreDepth = bbsm_pkg::MaxFftLength / 2 + 1;
  localparam int WatchLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 120;

  // Predicts the masking stage: keeps its own bin store, band sums and
  // indexes, and queues the read-out results it expects.
  class mask_scoreboard;
    int unsigned band_edge[bbsm_pkg::BandCount] = '{
      101, 204, 309, 417, 531, 651, 781, 922, 1079, 1255, 1456, 1691,
      1968, 2303, 2711, 3211, 3822, 4554, 5412, 6414, 7617, 9167, 11415, 15429};
    int unsigned hear_thr2[bbsm_pkg::BandCount] = '{
      1000, 600, 300, 200, 100, 40, 20, 10, 4, 2, 1, 1,
      1, 2, 4, 10, 20, 40, 100, 200, 400, 1000, 2000, 4000};
    longint unsigned rate_hz;
    int unsigned     len_reg;
    longint unsigned thr_gain;
    logic [23:0]     bin_re [StoreDepth];
    logic [23:0]     bin_im [StoreDepth];
    bit              bin_written [StoreDepth];
    longint unsigned band_sum [bbsm_pkg::BandCount];
    int unsigned     load_ix, read_ix, mask_cnt;
    bbsm_pkg::out_item_t readout_q[$];
    int unsigned     errors, readouts, masked_bins, frames;

    function new();
      rate_hz = bbsm_pkg::SampleRateReset;
      len_reg = bbsm_pkg::FftLengthReset;
      thr_gain = bbsm_pkg::ThrMultReset;
      foreach (bin_written[i]) bin_written[i] = 1'b0;
      foreach (band_sum[i]) band_sum[i] = 0;
      load_ix = 0;
      read_ix = 0;
      mask_cnt = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [17:0] val);
      case (idx)
        bbsm_pkg::RegSampleRate: rate_hz = val;
        bbsm_pkg::RegFftLength:  len_reg = val[11:0];
        bbsm_pkg::RegThrMult:    thr_gain = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      if (len_reg < 16) return 16;
      if (len_reg > bbsm_pkg::MaxFftLength) return bbsm_pkg::MaxFftLength;
      return len_reg;
    endfunction

    function int unsigned frame_bins();
      return eff_len() / 2 + 1;
    endfunction

    function int unsigned band_for(int unsigned bin);
      longint unsigned f;
      int unsigned b;
      f = longint'(bin) * rate_hz;
      b = 0;
      foreach (band_edge[k])
        if (f >= longint'(band_edge[k]) * eff_len()) b++;
      return b;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function longint unsigned abs24(logic signed [23:0] x);
      longint signed v;
      v = x;
      return (v < 0) ? -v : v;
    endfunction

    // True when the next read-out hits a bin that has been written.
    function bit readable();
      return bin_written[read_ix];
    endfunction

    // Note an accepted transaction; return 0 when the block ignores it.
    function bit note_input(bbsm_pkg::in_item_t it);
      int unsigned band, idx;
      longint unsigned a, b, mag;
      bit masked, last;
      bbsm_pkg::out_item_t e;
      if (it.cmd == CmdLoad) begin
        if (load_ix >= frame_bins()) return 1'b0;
        if (load_ix == 0) begin
          foreach (band_sum[i]) band_sum[i] = 0;
          mask_cnt = 0;
          read_ix = 0;
        end
        bin_re[load_ix] = it.bin_real;
        bin_im[load_ix] = it.bin_imag;
        bin_written[load_ix] = 1'b1;
        band = band_for(load_ix);
        if (band < bbsm_pkg::BandCount) begin
          a = abs24(it.bin_real);
          b = abs24(it.bin_imag);
          mag = int_root(a * a + b * b);
          band_sum[band] += mag;
          if (band_sum[band] > 64'hFFFF_FFFF_FFFF) band_sum[band] = 64'hFFFF_FFFF_FFFF;
        end
        load_ix++;
        return 1'b1;
      end
      idx = read_ix;
      band = band_for(idx);
      last = (idx + 1 >= frame_bins());
      masked = (band < bbsm_pkg::BandCount) &&
               (2 * band_sum[band] < longint'(hear_thr2[band]) * thr_gain);
      if (masked) mask_cnt++;
      e.out_real = masked ? '0 : bin_re[idx];
      e.out_imag = masked ? '0 : bin_im[idx];
      e.out_masked = masked;
      e.out_last = last;
      e.masked_total = last ? mask_cnt[10:0] : '0;
      readout_q.push_back(e);
      if (last) begin
        read_ix = 0;
        load_ix = 0;
        mask_cnt = 0;
      end else begin
        read_ix = idx + 1;
      end
      return 1'b1;
    endfunction

    function void check(bbsm_pkg::out_item_t got);
      bbsm_pkg::out_item_t e;
      readouts++;
      if (readout_q.size() == 0) begin
        $error("unexpected read-out result %p", got);
        errors++;
        return;
      end
      e = readout_q.pop_front();
      masked_bins += got.out_masked;
      frames += got.out_last;
      if (got.out_real !== e.out_real) begin
        $error("out_real: expected %0d, got %0d", e.out_real, got.out_real);
        errors++;
      end
      if (got.out_imag !== e.out_imag) begin
        $error("out_imag: expected %0d, got %0d", e.out_imag, got.out_imag);
        errors++;
      end
      if (got.out_masked !== e.out_masked) begin
        $error("out_masked: expected %0d, got %0d", e.out_masked, got.out_masked);
        errors++;
      end
      if (got.out_last !== e.out_last) begin
        $error("out_last: expected %0d, got %0d", e.out_last, got.out_last);
        errors++;
      end
      if (got.masked_total !== e.masked_total) begin
        $error("masked_total: expected %0d, got %0d", e.masked_total, got.masked_total);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  bbsm_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bbsm_pkg::out_item_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = bbsm_pkg::RegSampleRate;
  logic [17:0]         cfg_data_i = '0;

  mask_scoreboard sb = new();
  bit          calm = 1'b1;     // no idling on either side while set
  bit          hold_req = 1'b0; // ask the receiver for one long hold-off
  int unsigned quiet_cycles = 0;
  int unsigned items_done = 0;

  bark_band_spectral_mask_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or one long hold-off on request so that a
  // result sits in the output register and the input backs up behind it.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  // Check each read-out transaction and watch for a hung handshake.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check(out_data_o);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("timeout: no transaction for %0d cycles", WatchLimit);
      $display("tb_top failed");
      $finish;
    end
  end

  // Offer one transaction, hold it until accepted, then maybe idle a little.
  task automatic send(bbsm_pkg::in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.note_input(it)) items_done++;
    gap = (!calm && $urandom_range(99) < 19) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_bin(logic signed [23:0] re, logic signed [23:0] im);
    bbsm_pkg::in_item_t it;
    it.cmd = CmdLoad;
    it.bin_real = re;
    it.bin_imag = im;
    send(it);
  endtask

  // Read out one bin; fall back to a load if that bin was never written.
  task automatic read_bin();
    bbsm_pkg::in_item_t it;
    it.cmd = CmdRead;
    it.bin_real = 24'($urandom());
    it.bin_imag = 24'($urandom());
    if (!sb.readable()) it.cmd = CmdLoad;
    send(it);
  endtask

  // Drop valid and wait until every read-out has arrived and the block settles.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.readout_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [17:0] rate, logic [11:0] len, logic [15:0] gain);
    drain();
    write_reg(bbsm_pkg::RegSampleRate, rate);
    write_reg(bbsm_pkg::RegFftLength, {6'd0, len});
    write_reg(bbsm_pkg::RegThrMult, {2'd0, gain});
  endtask

  // Mix of extremes, small values (likely masked) and full-range values.
  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return '0;
      3, 4: return 24'(int'($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic full_frame();
    int unsigned n;
    n = sb.frame_bins();
    repeat (n) load_bin(rand_sample(), rand_sample());
    repeat (n) read_bin();
  endtask

  initial begin
    int unsigned n, k, frame_no;
    logic [11:0] len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a length below range clamps to 16 (nine bins); field extremes,
    // one load past the end of the frame, the full read-out and a short replay.
    configure(18'd48000, 12'd8, 16'd256);
    load_bin(24'sh7FFFFF, 24'sh7FFFFF);
    load_bin(24'sh800000, 24'sh800000);
    load_bin(24'sh800000, 24'sh7FFFFF);
    load_bin('0, '0);
    load_bin(24'sh000001, -24'sh000001);
    load_bin('0, 24'sh800000);
    load_bin(24'sh7FFFFF, '0);
    load_bin(24'sh000100, 24'sh000010);
    load_bin(-24'sh000100, '0);
    load_bin(24'sh123456, 24'sh654321);
    repeat (9) read_bin();
    repeat (2) read_bin();

    // Extreme settings: zero rate, full-size length, lengths above and below range.
    configure(18'd0, 12'd16, 16'hFFFF);
    full_frame();
    configure(18'h3FFFF, 12'd2048, 16'd0);
    repeat (12) load_bin(rand_sample(), rand_sample());
    repeat (12) read_bin();
    configure(18'd192000, 12'hFFF, 16'hFFFF);
    repeat (12) load_bin(rand_sample(), rand_sample());
    repeat (12) read_bin();
    configure(18'd8000, 12'd0, 16'd1);
    full_frame();

    // Random part: mostly well-formed frames on small lengths, some noise.
    frame_no = 0;
    while (items_done < 1500) begin
      if (frame_no == 3) calm = 1'b0;
      if (frame_no % 4 == 0) begin
        case ($urandom_range(9))
          0: len = 12'($urandom_range(128, 512));
          1: len = 12'($urandom_range(0, 40));
          default: len = 12'd16 << $urandom_range(0, 2);
        endcase
        configure(18'($urandom_range(0, 3) == 0 ? $urandom()
                                                : $urandom_range(8000, 192000)),
                  len,
                  16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2048)));
      end
      n = sb.frame_bins();
      if (frame_no == 5) begin
        repeat (n) load_bin(rand_sample(), rand_sample());
        hold_req = 1'b1;
        repeat (n) read_bin();
      end else if ($urandom_range(99) < 80 || n > 300) begin
        full_frame();
      end else begin
        case ($urandom_range(2))
          0: begin
            repeat (n + $urandom_range(1, 3)) load_bin(rand_sample(), rand_sample());
            repeat (n) read_bin();
          end
          1: begin
            k = $urandom_range(1, n);
            repeat (k) load_bin(rand_sample(), rand_sample());
            repeat ($urandom_range(1, n)) read_bin();
          end
          default: repeat (n) read_bin();
        endcase
      end
      frame_no++;
    end

    drain();
    $display("covered %0d transactions, %0d read-outs, %0d masked bins, %0d frames",
             items_done, sb.readouts, sb.masked_bins, sb.frames);
    if (sb.errors == 0 && sb.readout_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      if (sb.readout_q.size() != 0)
        $error("%0d read-out results never arrived", sb.readout_q.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
